// ----- sv/tbst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbst_pkg: shared types and constants of the two-beam speed trap
// Field widths, register indexes, phase and sequencer codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tbst_pkg;

   // widths of the measurement datapath
   localparam int COUNT_BITS     = 16;
   localparam int SPEED_BITS     = 16;
   localparam int CSR_BITS       = 16;
   localparam int DIGIT_BITS     = 4;
   localparam int DIGIT_FIELDS   = 5;
   localparam int DECIMAL_DIGITS = 5;
   localparam int DIGIT_LIMIT    = (DECIMAL_DIGITS < DIGIT_FIELDS) ? DECIMAL_DIGITS
                                                                   : DIGIT_FIELDS;
   localparam int DCOUNT_BITS    = 3;
   localparam int STEP_BITS      = $clog2(SPEED_BITS);
   localparam int CSR_ADDR_BITS  = 2;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 40;

   // register reset values
   localparam logic [CSR_BITS-1:0] SPEED_CONSTANT_RST  = 16'd720;
   localparam logic [CSR_BITS-1:0] OVERSPEED_LIMIT_RST = 16'd72;
   localparam logic [CSR_BITS-1:0] HOLD_TICKS_RST      = 16'd10;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPEED_CONSTANT  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OVERSPEED_LIMIT = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HOLD_TICKS      = 2'd2;

   // measurement phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_MEASURE = 3'b010,
      PH_HOLD    = 3'b100
   } phase_type;

   // sequencer state
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_BCD  = 4'b0100,
      S_OUT  = 4'b1000
   } seq_type;

   // controller to datapath
   typedef struct packed {
      logic count_start;
      logic count_inc;
      logic div_load;
      logic div_step;
      logic bcd_step;
      logic hold_load;
      logic hold_dec;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hold_cfg_zero;
      logic hold_last;
      logic out_full;
   } sts_type;

endpackage

// ----- sv/two_beam_speed_trap_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_beam_speed_trap_core: vehicle speed trap with two light beams
// One request is one sensor tick; a result follows the tick that ends a run.
// ----------------------------------------------------------------------------
// Each request carries one tick of both beam levels. A tick with beam one
// blocked and beam two clear starts or extends a measurement; the first tick
// without that pattern ends it and yields one result with speed = constant /
// tick count, the overspeed flag and the decimal digits, after which ticks are
// ignored for hold_ticks requests. A tick that yields no result keeps req_tready
// high. A result-ending tick occupies the block through the bit-serial
// restoring divider, the shift-add-3 decimal converter and the load of the
// output register, which waits while that register still holds
// an untaken result; req_tready is low meanwhile. Register writes take effect
// on the next cycle.
module two_beam_speed_trap_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [0] beam_one, [1] beam_two, [7:2] zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tbst_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // response: [15:0] speed_value, [16] over_limit, [20:17] digit_4,
   // [24:21] digit_3, [28:25] digit_2, [32:29] digit_1, [36:33] digit_0,
   // [39:37] digit_count
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tbst_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // register writes
   input  logic                                 csr_wr_en,
   input  logic [tbst_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [tbst_pkg::CSR_BITS-1:0]        csr_wr_data
);
   import tbst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tbst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .beam_one   (req_tdata[0]),
      .beam_two   (req_tdata[1]),
      .cmd        (cmd),
      .sts        (sts)
   );

   tbst_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- sv/tbst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbst_ctrl: measurement phase tracking and result sequencer
// Takes one tick per request, tracks idle/measure/hold, and steps the
// datapath through division, decimal conversion and result hand-off.
// ----------------------------------------------------------------------------
module tbst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             beam_one,
   input  logic             beam_two,
   output tbst_pkg::cmd_type cmd,
   input  tbst_pkg::sts_type sts
);
   import tbst_pkg::*;

   seq_type               state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  pattern;
   logic                  step_last;

   assign pattern    = beam_one & ~beam_two;
   assign step_last  = (step_ff == STEP_BITS'(SPEED_BITS - 1));
   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (phase_ff)
                  PH_MEASURE: begin
                     if (pattern) begin
                        cmd.count_inc = 1'b1;
                     end else begin
                        // end of measurement: start the result sequence
                        cmd.div_load  = 1'b1;
                        cmd.hold_load = 1'b1;
                        phase_in      = sts.hold_cfg_zero ? PH_IDLE : PH_HOLD;
                        state_in      = S_DIV;
                        step_in       = '0;
                     end
                  end
                  PH_HOLD: begin
                     cmd.hold_dec = 1'b1;
                     if (sts.hold_last) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (pattern) begin
                        cmd.count_start = 1'b1;
                        phase_in        = PH_MEASURE;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_last) begin
               state_in = S_BCD;
               step_in  = '0;
            end
         end
         S_BCD: begin
            cmd.bcd_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_last) begin
               state_in = S_OUT;
               step_in  = '0;
            end
         end
         S_OUT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- sv/tbst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbst_dp: speed trap datapath
// Control registers, tick counter, hold countdown, restoring divider,
// shift-add-3 decimal converter and the result output register.
// ----------------------------------------------------------------------------
module tbst_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [tbst_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [tbst_pkg::CSR_BITS-1:0]         csr_wr_data,
   input  tbst_pkg::cmd_type                     cmd,
   output tbst_pkg::sts_type                     sts,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tbst_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import tbst_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // control registers
   logic [CSR_BITS-1:0] speed_const_ff, over_limit_cfg_ff, hold_cfg_ff;

   // measurement state
   logic [COUNT_BITS-1:0] elapsed_ff;
   logic [CSR_BITS-1:0]   hold_ff;

   // divider
   logic [COUNT_BITS-1:0] divisor_ff;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [SPEED_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS+1:0] trial;

   // decimal converter
   logic [SPEED_BITS-1:0]                     bin_ff;
   logic [DIGIT_FIELDS-1:0][DIGIT_BITS-1:0]   bcd_ff, bcd_adj, bcd_in;

   // result register
   logic                                      out_valid_ff;
   logic [SPEED_BITS-1:0]                     out_speed_ff;
   logic                                      out_over_ff;
   logic [DIGIT_FIELDS-1:0][DIGIT_BITS-1:0]   out_digit_ff, digit_masked;
   logic [DCOUNT_BITS-1:0]                    out_dcount_ff, dcount;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_const_ff    <= SPEED_CONSTANT_RST;
         over_limit_cfg_ff <= OVERSPEED_LIMIT_RST;
         hold_cfg_ff       <= HOLD_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_SPEED_CONSTANT:  speed_const_ff    <= csr_wr_data;
            CSR_OVERSPEED_LIMIT: over_limit_cfg_ff <= csr_wr_data;
            CSR_HOLD_TICKS:      hold_cfg_ff       <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // tick count and hold countdown
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         hold_ff    <= '0;
      end else begin
         if (cmd.count_start) begin
            elapsed_ff <= COUNT_BITS'(1);
         end else if (cmd.count_inc && elapsed_ff != COUNT_MAX) begin
            elapsed_ff <= elapsed_ff + 1'b1;
         end else if (cmd.div_load) begin
            elapsed_ff <= '0;
         end
         if (cmd.hold_load) begin
            hold_ff <= hold_cfg_ff;
         end else if (cmd.hold_dec && hold_ff != '0) begin
            hold_ff <= hold_ff - 1'b1;
         end
      end
   end

   assign sts.hold_cfg_zero = (hold_cfg_ff == '0);
   assign sts.hold_last     = (hold_ff[CSR_BITS-1:1] == '0);
   assign sts.out_full      = out_valid_ff & ~rsp_tready;

   // restoring divide step: one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[SPEED_BITS-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor_ff};
      if (trial[COUNT_BITS+1]) begin
         rem_in = shifted[COUNT_BITS-1:0];
         quo_in = {quo_ff[SPEED_BITS-2:0], 1'b0};
      end else begin
         rem_in = trial[COUNT_BITS-1:0];
         quo_in = {quo_ff[SPEED_BITS-2:0], 1'b1};
      end
   end

   // shift-add-3 step: adjust each digit, then shift the whole word left
   always_comb begin
      for (int i = 0; i < DIGIT_FIELDS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= DIGIT_BITS'(5)) ? bcd_ff[i] + DIGIT_BITS'(3) : bcd_ff[i];
      end
      bcd_in[0] = {bcd_adj[0][DIGIT_BITS-2:0], bin_ff[SPEED_BITS-1]};
      for (int i = 1; i < DIGIT_FIELDS; i++) begin
         bcd_in[i] = {bcd_adj[i][DIGIT_BITS-2:0], bcd_adj[i-1][DIGIT_BITS-1]};
      end
   end

   // divider and converter registers
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff     <= speed_const_ff;
         rem_ff     <= '0;
         divisor_ff <= (elapsed_ff == '0) ? COUNT_BITS'(1) : elapsed_ff;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         bin_ff <= quo_in;
         bcd_ff <= '0;
      end else if (cmd.bcd_step) begin
         bin_ff <= {bin_ff[SPEED_BITS-2:0], 1'b0};
         bcd_ff <= bcd_in;
      end
   end

   // digit masking and significant digit count
   always_comb begin
      dcount = DCOUNT_BITS'(1);
      for (int i = 0; i < DIGIT_FIELDS; i++) begin
         digit_masked[i] = (i < DIGIT_LIMIT) ? bcd_ff[i] : '0;
         if (bcd_ff[i] != '0) begin
            dcount = DCOUNT_BITS'(i + 1);
         end
      end
      if (dcount > DCOUNT_BITS'(DIGIT_LIMIT)) begin
         dcount = DCOUNT_BITS'(DIGIT_LIMIT);
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_speed_ff  <= quo_ff;
         out_over_ff   <= (quo_ff > over_limit_cfg_ff);
         out_digit_ff  <= digit_masked;
         out_dcount_ff <= dcount;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_dcount_ff,
                        out_digit_ff[0], out_digit_ff[1], out_digit_ff[2],
                        out_digit_ff[3], out_digit_ff[4],
                        out_over_ff, out_speed_ff};

endmodule
